>>> rtl/core/mtrc_pkg.sv
// Package for the Modbus TCP response checker: item types, codes and
// fixed constants shared by all modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mtrc_pkg;

   // Input item
   typedef struct packed {
      logic        func;
      logic [15:0] expected_tid;
      logic [1:0]  expected_kind;
      logic [7:0]  rx_byte;
   } req_item_type;

   // Result item
   typedef struct packed {
      logic        kind;
      logic [6:0]  reg_index;
      logic [15:0] reg_value;
      logic [2:0]  status;
      logic [7:0]  func_code;
      logic [7:0]  exc_code;
      logic        last;
   } rsp_item_type;

   // Up to two results caused by one input item, word first
   typedef struct packed {
      logic         word_valid;
      rsp_item_type word;
      logic         done_valid;
      rsp_item_type done;
   } push_type;

   localparam logic FUNC_ARM  = 1'b0;
   localparam logic FUNC_BYTE = 1'b1;

   localparam logic [1:0] KIND_READ         = 2'd0;
   localparam logic [1:0] KIND_WRITE_SINGLE = 2'd1;
   localparam logic [1:0] KIND_WRITE_MULTI  = 2'd2;

   localparam logic RESULT_WORD = 1'b0;
   localparam logic RESULT_DONE = 1'b1;

   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_LEN    = 3'd1;
   localparam logic [2:0] ST_HDR_BAD    = 3'd2;
   localparam logic [2:0] ST_EXCEPTION  = 3'd3;
   localparam logic [2:0] ST_WRONG_FUNC = 3'd4;
   localparam logic [2:0] ST_FEW_REGS   = 3'd5;

   localparam logic [7:0] FC_READ_HOLDING  = 8'h03;
   localparam logic [7:0] FC_WRITE_SINGLE  = 8'h06;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'h10;
   localparam int         FC_EXC_BIT       = 7;
   localparam int         MIN_STATUS_REGS  = 7;
   localparam logic [7:0] MIN_BYTE_CNT     = 8'(MIN_STATUS_REGS * 2);

   // Frame byte positions
   localparam logic [16:0] POS_TID_HI   = 17'd0;
   localparam logic [16:0] POS_TID_LO   = 17'd1;
   localparam logic [16:0] POS_PROTO_HI = 17'd2;
   localparam logic [16:0] POS_PROTO_LO = 17'd3;
   localparam logic [16:0] POS_LEN_HI   = 17'd4;
   localparam logic [16:0] POS_LEN_LO   = 17'd5;
   localparam logic [16:0] POS_UNIT     = 17'd6;
   localparam logic [16:0] POS_FUNC     = 17'd7;
   localparam logic [16:0] POS_BCNT     = 17'd8;
   localparam logic [16:0] POS_DATA     = 17'd9;
   localparam logic [16:0] HDR_LEN      = 17'd5;
   localparam logic [15:0] MIN_LEN      = 16'd3;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;
   localparam int QUEUE_CW    = 3;

endpackage

`default_nettype wire

>>> rtl/core/modbus_tcp_response_checker.sv
// Top level of the Modbus TCP response checker.
// Depends on mtrc_pkg, mtrc_frame_checker and mtrc_result_queue.
`timescale 1ns / 1ps
`default_nettype none

// Checks one Modbus TCP response, one byte per item. An arm item (func 0)
// loads the expected transaction id and request kind and arms the block;
// byte items (func 1) are framed by the MBAP length field and checked for
// header match (transaction id, protocol 0, unit id from csr_write_data),
// exception bit, function code and, for reads, byte count. Each register word
// of a good read leaves as a result item when its second byte arrives; the
// last frame byte leaves a completion item with a status code and disarms.
// Bytes while not armed are dropped. Rate: one item per cycle while the
// result queue has room for two results. An accepted item is held in the
// input register and checked straight out of it once the queue has room;
// its results are written into a four-entry result queue at the end of
// that cycle and offered from the queue head. A byte may cause two results
// (last word plus completion); the queue absorbs that, and input stalls
// only when the result side stalls and fewer than two queue slots are free.
// Configuration is a single write cycle, unit id 0 is stored as 1.

module modbus_tcp_response_checker
   import mtrc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output rsp_item_type      rsp_item,
   input  wire logic         csr_write_enable,
   input  wire logic [7:0]   csr_write_data
);

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff,  in_item_in;
   logic [7:0]    unit_id_ff,  unit_id_in;
   logic          req_take;
   logic          stage_go;
   logic          room;
   logic          armed;
   push_type      push;

   // Advance the input register whenever the queue can hold two results
   assign stage_go  = in_valid_ff && room;
   assign req_ready = !in_valid_ff || stage_go;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
         in_item_in  = req_item;
      end else if (stage_go) begin
         in_valid_in = 1'b0;
      end
   end

   // Hold unit id; a write of zero counts as one
   assign unit_id_in = !csr_write_enable     ? unit_id_ff :
                       (csr_write_data == 8'd0) ? 8'd1 : csr_write_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         unit_id_ff  <= 8'd1;
      end else begin
         in_valid_ff <= in_valid_in;
         unit_id_ff  <= unit_id_in;
      end
   end

   always_ff @(posedge clock) begin
      in_item_ff <= in_item_in;
   end

   mtrc_frame_checker u_checker (
      .clock   (clock),
      .reset   (reset),
      .step    (stage_go),
      .item    (in_item_ff),
      .unit_id (unit_id_ff),
      .push    (push),
      .armed   (armed)
   );

   mtrc_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop        (rsp_ready),
      .head_valid (rsp_valid),
      .head       (rsp_item),
      .room       (room)
   );

   // A completion always disarms the checker
   a_done_disarms: assert property (@(posedge clock) disable iff (reset)
      push.done_valid |=> !armed)
      else $error("checker still armed after a completion item");

   // Register words only come from an armed checker
   a_word_needs_armed: assert property (@(posedge clock) disable iff (reset)
      push.word_valid |-> armed && stage_go)
      else $error("register word produced while not armed or not stepping");

   // Two results from one byte only when the word is the frame's last one
   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      (push.word_valid && push.done_valid) |-> !push.word.last && push.done.last)
      else $error("word and completion pushed with wrong last flags");

endmodule

`default_nettype wire

>>> rtl/core/mtrc_frame_checker.sv
// Frame state and checks of the Modbus TCP response checker.
// Depends on mtrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtrc_frame_checker
   import mtrc_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire req_item_type item,
   input  wire logic [7:0]   unit_id,
   output push_type          push,
   output logic              armed
);

   logic        armed_ff,       armed_in;
   logic [15:0] want_tid_ff,    want_tid_in;
   logic [1:0]  want_kind_ff,   want_kind_in;
   logic [16:0] byte_pos_ff,    byte_pos_in;
   logic [15:0] frame_len_ff,   frame_len_in;
   logic        header_bad_ff,  header_bad_in;
   logic [7:0]  seen_func_ff,   seen_func_in;
   logic [7:0]  byte_cnt_ff,    byte_cnt_in;
   logic [2:0]  verdict_ff,     verdict_in;
   logic [7:0]  high_byte_ff,   high_byte_in;
   logic [6:0]  word_idx_ff,    word_idx_in;

   logic [16:0] offset;
   logic [2:0]  done_status;

   // Verdict taken once the byte count arrives
   function automatic logic [2:0] decide(
      input logic        hdr_bad,
      input logic [7:0]  fc,
      input logic [1:0]  want,
      input logic [15:0] flen,
      input logic [7:0]  bcnt
   );
      logic [2:0] st;
      begin
         if (hdr_bad) begin
            st = ST_HDR_BAD;
         end else if (fc[FC_EXC_BIT]) begin
            st = ST_EXCEPTION;
         end else begin
            case (want)
               KIND_READ: begin
                  if (fc != FC_READ_HOLDING) begin
                     st = ST_WRONG_FUNC;
                  end else if (bcnt < MIN_BYTE_CNT ||
                               {1'b0, flen} < 17'(bcnt) + 17'(MIN_LEN)) begin
                     st = ST_FEW_REGS;
                  end else begin
                     st = ST_OK;
                  end
               end
               KIND_WRITE_SINGLE: st = (fc == FC_WRITE_SINGLE) ? ST_OK : ST_WRONG_FUNC;
               KIND_WRITE_MULTI:  st = (fc == FC_WRITE_MULTI) ? ST_OK : ST_WRONG_FUNC;
               default:           st = ST_WRONG_FUNC;
            endcase
         end
         decide = st;
      end
   endfunction

   always_comb begin
      armed_in      = armed_ff;
      want_tid_in   = want_tid_ff;
      want_kind_in  = want_kind_ff;
      byte_pos_in   = byte_pos_ff;
      frame_len_in  = frame_len_ff;
      header_bad_in = header_bad_ff;
      seen_func_in  = seen_func_ff;
      byte_cnt_in   = byte_cnt_ff;
      verdict_in    = verdict_ff;
      high_byte_in  = high_byte_ff;
      word_idx_in   = word_idx_ff;
      push          = '0;
      offset        = byte_pos_ff - POS_DATA;
      done_status   = ST_OK;

      if (step && item.func == FUNC_ARM) begin
         armed_in      = 1'b1;
         want_tid_in   = item.expected_tid;
         want_kind_in  = item.expected_kind;
         byte_pos_in   = '0;
         frame_len_in  = '0;
         header_bad_in = 1'b0;
         seen_func_in  = '0;
         byte_cnt_in   = '0;
         verdict_in    = ST_OK;
         high_byte_in  = '0;
         word_idx_in   = '0;
      end else if (step && armed_ff) begin
         case (byte_pos_ff)
            POS_TID_HI: begin
               if (item.rx_byte != want_tid_ff[15:8]) header_bad_in = 1'b1;
            end
            POS_TID_LO: begin
               if (item.rx_byte != want_tid_ff[7:0]) header_bad_in = 1'b1;
            end
            POS_PROTO_HI, POS_PROTO_LO: begin
               if (item.rx_byte != 8'd0) header_bad_in = 1'b1;
            end
            POS_LEN_HI: frame_len_in = {item.rx_byte, 8'd0};
            POS_LEN_LO: frame_len_in = {frame_len_ff[15:8], item.rx_byte};
            POS_UNIT: begin
               if (item.rx_byte != unit_id) header_bad_in = 1'b1;
            end
            POS_FUNC: seen_func_in = item.rx_byte;
            POS_BCNT: begin
               byte_cnt_in = item.rx_byte;
               verdict_in  = decide(header_bad_ff, seen_func_ff, want_kind_ff,
                                    frame_len_ff, item.rx_byte);
            end
            default: begin
               // Register data: pair bytes into words, ignore an odd tail
               if (want_kind_ff == KIND_READ && verdict_ff == ST_OK &&
                   offset < {9'd0, byte_cnt_ff[7:1], 1'b0}) begin
                  if (!offset[0]) begin
                     high_byte_in = item.rx_byte;
                  end else begin
                     push.word_valid       = 1'b1;
                     push.word.kind        = RESULT_WORD;
                     push.word.reg_index   = word_idx_ff;
                     push.word.reg_value   = {high_byte_ff, item.rx_byte};
                     push.word.status      = ST_OK;
                     push.word.func_code   = seen_func_ff;
                     push.word.exc_code    = 8'd0;
                     push.word.last        = 1'b1;
                     word_idx_in           = word_idx_ff + 7'd1;
                  end
               end
            end
         endcase

         if (byte_pos_ff == HDR_LEN + {1'b0, frame_len_in}) begin
            done_status = (frame_len_in < MIN_LEN) ? ST_BAD_LEN : verdict_in;
            push.word.last        = 1'b0;
            push.done_valid       = 1'b1;
            push.done.kind        = RESULT_DONE;
            push.done.reg_index   = '0;
            push.done.reg_value   = '0;
            push.done.status      = done_status;
            push.done.func_code   = seen_func_in;
            push.done.exc_code    = (done_status == ST_EXCEPTION) ? byte_cnt_in : 8'd0;
            push.done.last        = 1'b1;
            armed_in      = 1'b0;
            byte_pos_in   = '0;
            frame_len_in  = '0;
            header_bad_in = 1'b0;
            seen_func_in  = '0;
            byte_cnt_in   = '0;
            verdict_in    = ST_OK;
            high_byte_in  = '0;
            word_idx_in   = '0;
         end else begin
            byte_pos_in = byte_pos_ff + 17'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff      <= 1'b0;
         want_tid_ff   <= '0;
         want_kind_ff  <= '0;
         byte_pos_ff   <= '0;
         frame_len_ff  <= '0;
         header_bad_ff <= 1'b0;
         seen_func_ff  <= '0;
         byte_cnt_ff   <= '0;
         verdict_ff    <= ST_OK;
         high_byte_ff  <= '0;
         word_idx_ff   <= '0;
      end else begin
         armed_ff      <= armed_in;
         want_tid_ff   <= want_tid_in;
         want_kind_ff  <= want_kind_in;
         byte_pos_ff   <= byte_pos_in;
         frame_len_ff  <= frame_len_in;
         header_bad_ff <= header_bad_in;
         seen_func_ff  <= seen_func_in;
         byte_cnt_ff   <= byte_cnt_in;
         verdict_ff    <= verdict_in;
         high_byte_ff  <= high_byte_in;
         word_idx_ff   <= word_idx_in;
      end
   end

   assign armed = armed_ff;

endmodule

`default_nettype wire

>>> rtl/core/mtrc_result_queue.sv
// Small result queue: takes up to two results a cycle, gives one.
// Depends on mtrc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtrc_result_queue
   import mtrc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire push_type push,
   input  wire logic     pop,
   output logic          head_valid,
   output rsp_item_type  head,
   output logic          room
);

   rsp_item_type            entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]     count_ff,  count_in;
   logic [1:0]              n_push;
   logic                    do_pop;

   assign n_push     = {1'b0, push.word_valid} + {1'b0, push.done_valid};
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];
   assign do_pop     = pop && head_valid;
   assign room       = (count_ff <= QUEUE_CW'(QUEUE_DEPTH - 2));

   assign wr_ptr_in = wr_ptr_ff + QUEUE_AW'(n_push);
   assign rd_ptr_in = rd_ptr_ff + QUEUE_AW'(do_pop);
   assign count_in  = count_ff + QUEUE_CW'(n_push) - QUEUE_CW'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Payload storage, word ahead of completion
   always_ff @(posedge clock) begin
      if (push.word_valid) begin
         entry_ff[wr_ptr_ff] <= push.word;
         if (push.done_valid) begin
            entry_ff[wr_ptr_ff + QUEUE_AW'(1)] <= push.done;
         end
      end else if (push.done_valid) begin
         entry_ff[wr_ptr_ff] <= push.done;
      end
   end

endmodule

`default_nettype wire
